FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on the rising edge, off during reset.
`define PSNM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("palette match check failed");

// Next-cycle implication, clocked on the rising edge, off during reset.
`define PSNM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("palette match check failed");

`endif

FILE: rtl/psnm_pkg.sv
// Shared types and constants of the palette shade and nearest match unit.
package psnm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_SHADE   = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  localparam logic [17:0] NO_MATCH_DIST = 18'h2fa03;
  localparam logic [17:0] STOP_DIST     = 18'h00040;
  localparam logic [17:0] KEEP_DIST     = 18'h00201;

  // Output of the distance unit.
  typedef struct packed {
    logic        valid;
    logic [17:0] sq_sum;
  } dist_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  match_index;
    logic [17:0] match_distance;
    logic        was_appended;
    logic [23:0] read_color;
    logic [8:0]  used_count;
  } rsp_t;

endpackage

FILE: rtl/psnm_if.sv
// Request and result channel interfaces of the palette match unit.
interface psnm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  entry_index;
  logic [23:0] color_word;
  logic [3:0]  brightness;

  modport source (output valid, operation, entry_index, color_word, brightness,
                  input ready);
  modport sink   (input valid, operation, entry_index, color_word, brightness,
                  output ready);
endinterface

interface psnm_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  match_index;
  logic [17:0] match_distance;
  logic        was_appended;
  logic [23:0] read_color;
  logic [8:0]  used_count;

  modport source (output valid, match_index, match_distance, was_appended,
                  read_color, used_count, input ready);
  modport sink   (input valid, match_index, match_distance, was_appended,
                  read_color, used_count, output ready);
endinterface

FILE: rtl/psnm_dist.sv
// Two-stage squared RGB distance unit, shared by every entry of a scan.
module psnm_dist (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic              kill_i,
  input  logic [23:0]       shade_i,
  input  logic [23:0]       entry_i,
  output psnm_pkg::dist_t   dist_o
);

  logic signed [15:0] diff [3];
  logic [15:0]        sq_d [3];
  logic [15:0]        sq_q [3];
  logic               valid_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = $signed({8'd0, shade_i[8*c +: 8]}) - $signed({8'd0, entry_i[8*c +: 8]});
      sq_d[c] = 16'(diff[c] * diff[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i && !kill_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      sq_q[c] <= sq_d[c];
    end
  end

  assign dist_o.valid  = valid_q;
  assign dist_o.sq_sum = 18'(sq_q[0]) + 18'(sq_q[1]) + 18'(sq_q[2]);

endmodule

FILE: rtl/palette_shade_nearest_match_unit.sv
// Palette shade and nearest match unit: top level with sequencer and palette memory.
//
// Keeps an RGB palette in a single-port-write, single-port-read memory and a
// count of entries in use. Every request gives exactly one result. A load or
// a restart goes from the transfer straight to the result state; a read
// passes the read state first. A shade passes the transfer, the scaling of
// the three channels on one shared multiplier, then one palette entry per cycle
// through the two-stage distance unit (one memory read per cycle sets this)
// until it drains, then a decide and a result state; the scan ends early at
// the first entry closer than 64. A new request is taken only once the
// previous one has finished; a result waiting in the output register does not
// hold off the next request. base_count sits at byte address 0 of the APB port;
// the user must write it only while the unit is idle; the unit does not enforce it.
module palette_shade_nearest_match_unit #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  psnm_req_if.sink    req_i,
  psnm_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int UW = $clog2(PALETTE_DEPTH + 1);
  localparam int XW = (IW > 8) ? IW : 8;
  localparam int BW = (UW > 10) ? UW : 10;
  localparam logic [11:0] SCALE_MUL = 12'h111;
  localparam logic [7:0]  CH_MAX    = 8'hff;
  localparam logic [7:0]  CH_MASK   = 8'hf8;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_SCALE  = 6'b000100,
    ST_SCAN   = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  function automatic logic [7:0] shade_chan(logic [7:0] src, logic [19:0] prod);
    logic [8:0] sum;
    logic [7:0] sat;
    sum = 9'(src) + 9'(prod[19:12]);
    sat = (sum > 9'(CH_MAX)) ? CH_MAX : sum[7:0];
    return sat & CH_MASK;
  endfunction

  state_e            state_q, state_d;
  logic [8:0]        base_q;
  logic [UW-1:0]     used_q;
  logic [UW-1:0]     scan_cnt_q;
  logic [1:0]        ch_q;
  logic              stop_q;
  logic              p1_v_q;
  logic              out_valid_q;
  logic [IW-1:0]     p1_idx_q, p2_idx_q;
  logic [17:0]       best_q;
  logic [IW-1:0]     best_idx_q;
  logic [7:0]        idx_q;
  logic              oob_q;
  logic [23:0]       light_q;
  logic [11:0]       scale_q;
  logic [23:0]       shaded_q;
  logic [23:0]       rd_data_q;
  psnm_pkg::rsp_t    res_q, out_q;
  logic [23:0]       pal_mem_q [PALETTE_DEPTH];

  logic              accept, cfg_wr, issue, scan_done, hit, append, out_free;
  logic [XW-1:0]     idx_x;
  logic              oob_now;
  logic              rd_en, wr_en;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic [23:0]       wr_data;
  logic [23:0]       src;
  logic [7:0]        light_ch, src_ch, new_ch;
  logic [19:0]       prod;
  logic [UW-1:0]     restart_cnt;
  psnm_pkg::op_e     op;
  psnm_pkg::dist_t   dist_res;

  assign op       = psnm_pkg::op_e'(req_i.operation);
  assign accept   = req_i.valid && req_i.ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? 32'(base_q) : 32'd0;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign idx_x   = XW'(req_i.entry_index);
  assign oob_now = {1'b0, idx_x} >= (XW + 1)'(PALETTE_DEPTH);

  assign restart_cnt = (BW'(base_q) > BW'(PALETTE_DEPTH)) ? UW'(PALETTE_DEPTH)
                                                           : UW'(base_q);

  // Channel scaling: one multiplier, one channel per cycle.
  assign src = oob_q ? 24'd0 : rd_data_q;
  always_comb begin
    case (ch_q)
      2'd0:    begin light_ch = light_q[7:0];   src_ch = src[7:0];   end
      2'd1:    begin light_ch = light_q[15:8];  src_ch = src[15:8];  end
      default: begin light_ch = light_q[23:16]; src_ch = src[23:16]; end
    endcase
  end
  assign prod   = 20'(light_ch) * 20'(scale_q);
  assign new_ch = shade_chan(src_ch, prod);

  // Scan: issue one read per cycle; the read data and distance are each registered.
  assign issue     = (state_q == ST_SCAN) && !stop_q && (scan_cnt_q < used_q);
  assign hit       = (state_q == ST_SCAN) && dist_res.valid && !stop_q &&
                     (dist_res.sq_sum < best_q);
  assign scan_done = stop_q || (!(scan_cnt_q < used_q) && !p1_v_q && !dist_res.valid);

  psnm_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p1_v_q),
    .kill_i  (stop_q),
    .shade_i (shaded_q),
    .entry_i (rd_data_q),
    .dist_o  (dist_res)
  );

  assign append = !((best_q < psnm_pkg::KEEP_DIST) ||
                    (BW'(idx_q) >= BW'(base_q) + BW'(4)) ||
                    (used_q >= UW'(PALETTE_DEPTH)));

  // Memory port selection.
  assign rd_en   = accept || issue;
  assign rd_addr = (state_q == ST_SCAN) ? scan_cnt_q[IW-1:0] : idx_x[IW-1:0];
  assign wr_en   = (accept && (op == psnm_pkg::OP_LOAD) && !oob_now) ||
                   ((state_q == ST_DECIDE) && append);
  assign wr_addr = (state_q == ST_DECIDE) ? used_q[IW-1:0] : idx_x[IW-1:0];
  assign wr_data = (state_q == ST_DECIDE) ? shaded_q : req_i.color_word;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pal_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= pal_mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            psnm_pkg::OP_READ:  state_d = ST_READ;
            psnm_pkg::OP_SHADE: state_d = ST_SCALE;
            default:            state_d = ST_FINISH;
          endcase
        end
      end
      ST_READ:   state_d = ST_FINISH;
      ST_SCALE:  if (ch_q == 2'd2) state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      base_q      <= '0;
      used_q      <= '0;
      scan_cnt_q  <= '0;
      ch_q        <= '0;
      stop_q      <= 1'b0;
      p1_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p1_v_q  <= issue;
      if (cfg_wr && (paddr[2] == 1'b0)) begin
        base_q <= pwdata[8:0];
      end
      if (accept) begin
        scan_cnt_q <= '0;
        ch_q       <= '0;
        stop_q     <= 1'b0;
        if (op == psnm_pkg::OP_RESTART) begin
          used_q <= restart_cnt;
        end
      end
      if (state_q == ST_SCALE) begin
        ch_q <= ch_q + 2'd1;
      end
      if (issue) begin
        scan_cnt_q <= scan_cnt_q + UW'(1);
      end
      if (hit && (dist_res.sq_sum < psnm_pkg::STOP_DIST)) begin
        stop_q <= 1'b1;
      end
      if ((state_q == ST_DECIDE) && append) begin
        used_q <= used_q + UW'(1);
      end
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    p1_idx_q <= scan_cnt_q[IW-1:0];
    p2_idx_q <= p1_idx_q;
    if (accept) begin
      idx_q      <= req_i.entry_index;
      oob_q      <= oob_now;
      light_q    <= req_i.color_word;
      scale_q    <= 12'(16'(req_i.brightness) * 16'(SCALE_MUL));
      best_q     <= psnm_pkg::NO_MATCH_DIST;
      best_idx_q <= '0;
      res_q      <= '0;
    end
    if (state_q == ST_READ) begin
      res_q.read_color <= src;
    end
    if (state_q == ST_SCALE) begin
      case (ch_q)
        2'd0:    shaded_q[7:0]   <= new_ch;
        2'd1:    shaded_q[15:8]  <= new_ch;
        default: shaded_q[23:16] <= new_ch;
      endcase
    end
    if (hit) begin
      best_q     <= dist_res.sq_sum;
      best_idx_q <= p2_idx_q;
    end
    if (state_q == ST_DECIDE) begin
      res_q.match_distance <= best_q;
      res_q.was_appended   <= append;
      res_q.match_index    <= append ? 8'(used_q) : 8'(best_idx_q);
    end
    if ((state_q == ST_FINISH) && out_free) begin
      out_q <= '{match_index:    res_q.match_index,
                 match_distance: res_q.match_distance,
                 was_appended:   res_q.was_appended,
                 read_color:     res_q.read_color,
                 used_count:     9'(used_q)};
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.match_index    = out_q.match_index;
  assign rsp_o.match_distance = out_q.match_distance;
  assign rsp_o.was_appended   = out_q.was_appended;
  assign rsp_o.read_color     = out_q.read_color;
  assign rsp_o.used_count     = out_q.used_count;

endmodule

FILE: rtl/psnm_chk.sv
// Port-level checker for the palette match unit, bound to the top level.
`include "assert_macros.svh"

module psnm_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [7:0]  rsp_match_index_i,
  input logic [17:0] rsp_match_distance_i,
  input logic        rsp_was_appended_i,
  input logic [23:0] rsp_read_color_i
);

  // A waiting result stays valid and keeps its match index and distance until the transfer.
  `PSNM_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_match_index_i) && $stable(rsp_match_distance_i))

  // One request at a time: busy right after a transfer.
  `PSNM_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // Only a far colour is appended, and a shade never carries read data.
  `PSNM_ASSERT_NOW(a_append_far, clk_i, rst_ni, rsp_valid_i && rsp_was_appended_i, (rsp_match_distance_i >= psnm_pkg::KEEP_DIST) && (rsp_read_color_i == 24'd0))

  `PSNM_ASSERT_NOW(a_dist_range, clk_i, rst_ni, rsp_valid_i, rsp_match_distance_i <= psnm_pkg::NO_MATCH_DIST)

endmodule

bind palette_shade_nearest_match_unit psnm_chk u_psnm_chk (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_match_index_i    (rsp_o.match_index),
  .rsp_match_distance_i (rsp_o.match_distance),
  .rsp_was_appended_i   (rsp_o.was_appended),
  .rsp_read_color_i     (rsp_o.read_color)
);
